// ===== hdl/rsbm_pkg.sv =====
// Shared types, codes and constants for the RAID stripe block mapper.
// Used by every module of the block; depends on nothing else.
package rsbm_pkg;

   // Widths fixed by the interface.
   localparam int ADDR_BITS   = 32;  // logical and member block numbers
   localparam int UNIT_BITS   = 16;  // stripe unit register
   localparam int NDISK_BITS  = 5;   // num_disks register
   localparam int DISK_BITS   = 4;   // disk numbers on the ports
   localparam int COUNT_BITS  = 7;   // block_count field
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // Volume limits.
   localparam int MAX_DISKS = 16;
   localparam int MAX_RUN   = 64;

   // Reset values of the configuration registers.
   localparam logic [NDISK_BITS-1:0] NUM_DISKS_RESET   = NDISK_BITS'(4);
   localparam logic [UNIT_BITS-1:0]  STRIPE_UNIT_RESET = UNIT_BITS'(4);
   localparam logic                  PARITY_MODE_RESET = 1'b0;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_DISKS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STRIPE_UNIT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PARITY_MODE = 2'd2;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_MAP     = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_FAIL    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_REPLACE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DEGRADED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNAVAIL  = 2'd2;

   // Disk failure or replace event toward the health tracker.
   typedef struct packed {
      logic                 valid;
      logic                 fail;
      logic [DISK_BITS-1:0] disk;
   } evt_type;

   // Health summary of the volume.
   typedef struct packed {
      logic [MAX_DISKS-1:0] down;
      logic                 single_down;
   } health_type;

   // Request to the shared divider.
   typedef struct packed {
      logic                 start;
      logic [ADDR_BITS-1:0] dividend;
      logic [UNIT_BITS-1:0] divisor;
   } div_req_type;

   // Answer from the shared divider.
   typedef struct packed {
      logic                 done;
      logic [ADDR_BITS-1:0] quotient;
      logic [UNIT_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hdl/raid_stripe_block_mapper_unit.sv =====
// Top level of the RAID stripe block mapper: ports, configuration, sequencer.
// Depends on rsbm_pkg, rsbm_div and rsbm_health.

// A map command turns a run of up to 64 logical blocks into one result per
// block: member disk, block on that disk, parity disk and a status; an
// unavailable block ends the run early. Each block goes twice through the one
// shared 32-step divider (block by stripe unit, then stripe by data disk
// count), and the 32x16 row product is registered as the second division
// finishes. Failure and replace commands give no result. req_stall is high
// while a run is being mapped; a finished result waits in the output register
// while the next block runs. Configuration is to be written only while the
// block is idle; the block itself does not enforce this.
module raid_stripe_block_mapper_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rsbm_pkg::CMD_BITS-1:0]        req_command,
   input  logic [rsbm_pkg::ADDR_BITS-1:0]       req_first_block,
   input  logic [rsbm_pkg::COUNT_BITS-1:0]      req_block_count,
   input  logic [rsbm_pkg::DISK_BITS-1:0]       req_disk_number,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rsbm_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [rsbm_pkg::DISK_BITS-1:0]       rsp_member_disk,
   output logic [rsbm_pkg::ADDR_BITS-1:0]       rsp_member_block,
   output logic [rsbm_pkg::DISK_BITS-1:0]       rsp_parity_member,
   output logic                                 rsp_last_in_run,
   // Configuration write port
   input  logic                                 csr_write_enable,
   input  logic [rsbm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rsbm_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import rsbm_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DIV1_GO   = 3'd1;
   localparam logic [2:0] S_DIV1_WAIT = 3'd2;
   localparam logic [2:0] S_DIV2_GO   = 3'd3;
   localparam logic [2:0] S_DIV2_WAIT = 3'd4;
   localparam logic [2:0] S_EMIT      = 3'd5;

   localparam int PROD_BITS = ADDR_BITS + UNIT_BITS;

   // Configuration registers
   logic [NDISK_BITS-1:0] num_disks_ff;
   logic [UNIT_BITS-1:0]  stripe_unit_ff;
   logic                  parity_mode_ff;

   // Sequencer and run state
   logic [2:0]            state_ff, state_in;
   logic [ADDR_BITS-1:0]  run_block_ff, run_block_in;
   logic [COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic [UNIT_BITS-1:0]  offs_ff, offs_in;
   logic [DISK_BITS-1:0]  mdisk_ff, mdisk_in;
   logic [ADDR_BITS-1:0]  prod_ff, prod_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [DISK_BITS-1:0]   rsp_member_disk_ff, rsp_member_disk_in;
   logic [ADDR_BITS-1:0]   rsp_member_block_ff, rsp_member_block_in;
   logic [DISK_BITS-1:0]   rsp_parity_member_ff, rsp_parity_member_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                  req_xfer;
   logic                  slot_free;
   logic [NDISK_BITS-1:0] eff_disks;
   logic [NDISK_BITS-1:0] data_disks;
   logic [UNIT_BITS-1:0]  unit;
   logic [DISK_BITS-1:0]  parity_member;
   logic [COUNT_BITS-1:0] run_len;
   logic [PROD_BITS-1:0]  prod_full;
   logic [STATUS_BITS-1:0] blk_status;
   logic                  blk_last;
   logic                  blk_down;

   evt_type     evt;
   health_type  health;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_disks_ff   <= NUM_DISKS_RESET;
         stripe_unit_ff <= STRIPE_UNIT_RESET;
         parity_mode_ff <= PARITY_MODE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUM_DISKS:   num_disks_ff   <= csr_write_data[NDISK_BITS-1:0];
            CSR_STRIPE_UNIT: stripe_unit_ff <= csr_write_data[UNIT_BITS-1:0];
            CSR_PARITY_MODE: parity_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Volume geometry derived from the registers.
   always_comb begin
      if (num_disks_ff < NDISK_BITS'(2)) begin
         eff_disks = NDISK_BITS'(2);
      end else if (num_disks_ff > NDISK_BITS'(MAX_DISKS)) begin
         eff_disks = NDISK_BITS'(MAX_DISKS);
      end else begin
         eff_disks = num_disks_ff;
      end
   end

   assign data_disks    = parity_mode_ff ? (eff_disks - NDISK_BITS'(1)) : eff_disks;
   assign parity_member = parity_mode_ff ? data_disks[DISK_BITS-1:0] : '0;
   assign unit          = (stripe_unit_ff == '0) ? UNIT_BITS'(1) : stripe_unit_ff;

   // Run length saturated to the longest run.
   assign run_len = (req_block_count > COUNT_BITS'(MAX_RUN)) ?
                    COUNT_BITS'(MAX_RUN) : req_block_count;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Failure and replace events go straight to the health tracker.
   assign evt.valid = req_xfer && ((req_command == CMD_FAIL) || (req_command == CMD_REPLACE));
   assign evt.fail  = (req_command == CMD_FAIL);
   assign evt.disk  = req_disk_number;

   rsbm_health u_health (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .eff_disks (eff_disks),
      .health    (health)
   );

   // Divider operands: block by stripe unit first, then stripe by data disks.
   assign div_req.start    = (state_ff == S_DIV1_GO) || (state_ff == S_DIV2_GO);
   assign div_req.dividend = (state_ff == S_DIV2_GO) ? div_rsp.quotient : run_block_ff;
   assign div_req.divisor  = (state_ff == S_DIV2_GO) ?
                             UNIT_BITS'(data_disks) : unit;

   rsbm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Start of the stripe row on the member disk.
   assign prod_full = div_rsp.quotient * unit;

   // Status of the current block from the health summary.
   assign blk_down = health.down[mdisk_ff];
   always_comb begin
      if (!blk_down) begin
         blk_status = ST_OK;
      end else if (parity_mode_ff && health.single_down) begin
         blk_status = ST_DEGRADED;
      end else begin
         blk_status = ST_UNAVAIL;
      end
   end
   assign blk_last = (remaining_ff == COUNT_BITS'(1)) || (blk_status == ST_UNAVAIL);

   // Sequencer
   always_comb begin
      state_in             = state_ff;
      run_block_in         = run_block_ff;
      remaining_in         = remaining_ff;
      offs_in              = offs_ff;
      mdisk_in             = mdisk_ff;
      prod_in              = prod_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_status_in        = rsp_status_ff;
      rsp_member_disk_in   = rsp_member_disk_ff;
      rsp_member_block_in  = rsp_member_block_ff;
      rsp_parity_member_in = rsp_parity_member_ff;
      rsp_last_in          = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_command == CMD_MAP) && (run_len != '0)) begin
               run_block_in = req_first_block;
               remaining_in = run_len;
               state_in     = S_DIV1_GO;
            end
         end
         S_DIV1_GO: begin
            state_in = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (div_rsp.done) begin
               offs_in  = div_rsp.remainder;
               state_in = S_DIV2_GO;
            end
         end
         S_DIV2_GO: begin
            state_in = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            if (div_rsp.done) begin
               mdisk_in = div_rsp.remainder[DISK_BITS-1:0];
               prod_in  = prod_full[ADDR_BITS-1:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_status_in        = blk_status;
               rsp_member_disk_in   = mdisk_ff;
               rsp_member_block_in  = prod_ff + ADDR_BITS'(offs_ff);
               rsp_parity_member_in = parity_member;
               rsp_last_in          = blk_last;
               run_block_in         = run_block_ff + ADDR_BITS'(1);
               remaining_in         = remaining_ff - COUNT_BITS'(1);
               if (blk_last) begin
                  remaining_in = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_DIV1_GO;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         remaining_ff <= '0;
         run_block_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         run_block_ff <= run_block_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      offs_ff              <= offs_in;
      mdisk_ff             <= mdisk_in;
      prod_ff              <= prod_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_member_disk_ff   <= rsp_member_disk_in;
      rsp_member_block_ff  <= rsp_member_block_in;
      rsp_parity_member_ff <= rsp_parity_member_in;
      rsp_last_ff          <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_member_disk   = rsp_member_disk_ff;
   assign rsp_member_block  = rsp_member_block_ff;
   assign rsp_parity_member = rsp_parity_member_ff;
   assign rsp_last_in_run   = rsp_last_ff;

endmodule

// ===== hdl/rsbm_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on rsbm_pkg for widths and the request and answer structs.
module rsbm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rsbm_pkg::div_req_type req,
   output rsbm_pkg::div_rsp_type rsp
);
   import rsbm_pkg::*;

   localparam int CNT_BITS = $clog2(ADDR_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ADDR_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] quo_ff, quo_in;
   logic [UNIT_BITS-1:0] rem_ff, rem_in;
   logic [UNIT_BITS-1:0] dvs_ff, dvs_in;
   logic [UNIT_BITS:0]   shifted;
   logic [UNIT_BITS+1:0] trial;

   // One trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, quo_ff[ADDR_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // A borrow means the divisor did not fit: keep the shifted remainder.
         if (trial[UNIT_BITS+1]) begin
            rem_in = shifted[UNIT_BITS-1:0];
         end else begin
            rem_in = trial[UNIT_BITS-1:0];
         end
         quo_in = {quo_ff[ADDR_BITS-2:0], ~trial[UNIT_BITS+1]};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== hdl/rsbm_health.sv =====
// Member disk health tracker: down marks and the recorded first failure.
// Depends on rsbm_pkg for the event and health structs.
module rsbm_health (
   input  logic                                clock,
   input  logic                                reset,
   input  rsbm_pkg::evt_type                   evt,
   input  logic [rsbm_pkg::NDISK_BITS-1:0]     eff_disks,
   output rsbm_pkg::health_type                health
);
   import rsbm_pkg::*;

   logic [MAX_DISKS-1:0] down_ff, down_in;
   logic                 rec_ff, rec_in;
   logic [DISK_BITS-1:0] rec_disk_ff, rec_disk_in;
   logic [MAX_DISKS-1:0] vol_mask;
   logic [MAX_DISKS-1:0] down_vol;
   logic                 in_volume;

   // Events naming a disk outside the volume change nothing.
   assign in_volume = ({1'b0, evt.disk} < eff_disks);

   always_comb begin
      down_in     = down_ff;
      rec_in      = rec_ff;
      rec_disk_in = rec_disk_ff;
      if (evt.valid && in_volume) begin
         if (evt.fail) begin
            down_in[evt.disk] = 1'b1;
            if (!rec_ff) begin
               rec_in      = 1'b1;
               rec_disk_in = evt.disk;
            end
         end else begin
            down_in[evt.disk] = 1'b0;
            if (rec_ff && (rec_disk_ff == evt.disk)) begin
               rec_in      = 1'b0;
               rec_disk_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff     <= '0;
         rec_ff      <= 1'b0;
         rec_disk_ff <= '0;
      end else begin
         down_ff     <= down_in;
         rec_ff      <= rec_in;
         rec_disk_ff <= rec_disk_in;
      end
   end

   // Only disks inside the current volume count as down.
   always_comb begin
      for (int i = 0; i < MAX_DISKS; i++) begin
         vol_mask[i] = (NDISK_BITS'(i) < eff_disks);
      end
   end

   assign down_vol = down_ff & vol_mask;

   assign health.down        = down_vol;
   assign health.single_down = (down_vol != '0) &&
                               ((down_vol & (down_vol - MAX_DISKS'(1))) == '0);

endmodule

// ===== hdl/rsbm_checker.sv =====
// Port-level checker for the RAID stripe block mapper, bound to the top level.
// Depends on rsbm_pkg for widths and codes.
module rsbm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [rsbm_pkg::CMD_BITS-1:0]        req_command,
   input  logic [rsbm_pkg::COUNT_BITS-1:0]      req_block_count,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [rsbm_pkg::STATUS_BITS-1:0]     rsp_status,
   input  logic [rsbm_pkg::DISK_BITS-1:0]       rsp_member_disk,
   input  logic [rsbm_pkg::ADDR_BITS-1:0]       rsp_member_block,
   input  logic [rsbm_pkg::DISK_BITS-1:0]       rsp_parity_member,
   input  logic                                 rsp_last_in_run
);
   import rsbm_pkg::*;

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_member_disk) && $stable(rsp_member_block) &&
         $stable(rsp_parity_member) && $stable(rsp_last_in_run))
      else $error("stalled result changed");

   // An unavailable result always ends its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNAVAIL) |-> rsp_last_in_run)
      else $error("unavailable result without last_in_run");

   // In parity mode data never lands on the parity disk or above it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parity_member != '0) |-> (rsp_member_disk < rsp_parity_member))
      else $error("member disk at or above parity disk");

   // A nonempty map command keeps the input side busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_MAP) && (req_block_count != '0)
      |=> req_stall)
      else $error("input taken again while a run is in progress");

   // No result is offered straight out of reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind raid_stripe_block_mapper_unit rsbm_checker u_rsbm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_command       (req_command),
   .req_block_count   (req_block_count),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_member_disk   (rsp_member_disk),
   .rsp_member_block  (rsp_member_block),
   .rsp_parity_member (rsp_parity_member),
   .rsp_last_in_run   (rsp_last_in_run)
);
